### hw/rtl/fbba_pkg.sv
// fbba_pkg: shared constants for the free block bitmap allocator
// request codes, status codes, field widths and parameter defaults
// no dependencies
package fbba_pkg;

  localparam int MAX_BLOCKS_DEF = 32768;
  localparam int WORD_BITS_DEF  = 32;

  localparam int REQ_W     = 2;
  localparam int BLK_W     = 15;
  localparam int TOTAL_W   = 16;
  localparam int OUT_LIMIT = 32768;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd2;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_FREE_ZERO = 1'b1;

endpackage

### hw/rtl/fbba_ram.sv
// fbba_ram: generic simple dual port ram, one write and one registered read
// used for the free bitmap storage
// no dependencies
module fbba_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/fbba_scan.sv
// fbba_scan: first-fit search over one bitmap word
// masks blocks outside 1 .. limit-1 and finds the lowest free bit
// no dependencies
module fbba_scan #(
  parameter int WORD_BITS = 32,
  parameter int CMP_W     = 16,
  parameter int WB_LOG    = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [CMP_W-1:0]     base,
  input  logic [CMP_W-1:0]     limit,
  output logic                 hit,
  output logic [WB_LOG-1:0]    idx
);

  logic [CMP_W-1:0]     rem;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] masked;

  assign rem = limit - base;

  always_comb begin
    if (rem >= CMP_W'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (WORD_BITS'(1) << rem[WB_LOG-1:0]) - WORD_BITS'(1);
    end
    if (base == '0) begin
      mask[0] = 1'b0;
    end
  end

  assign masked = word & mask;
  assign hit    = |masked;

  // lowest set bit wins
  always_comb begin
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (masked[i]) begin
        idx = WB_LOG'(i);
      end
    end
  end

endmodule

### hw/rtl/free_block_bitmap_allocator.sv
// free_block_bitmap_allocator: first-fit block allocator over a free bitmap in ram
// a query or free goes through ST_DEC, ST_RD, ST_RMW and ST_FIN to m_tvalid; an allocate reads bitmap
// words in ST_SCAN (up to MAP_WORDS); free of block zero or outside the map, unknown request or allocate
// with no usable block go from ST_DEC straight to ST_FIN; one request in flight, the next accepted once
// the result is registered to m_tdata; a result held by m_tready low holds the next one in ST_FIN
// reset: rst clears control and total_blocks, then MAP_WORDS zero words are written with s_tready low
module free_block_bitmap_allocator
  import fbba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [TOTAL_W-1:0]   cfg_wdata,   // total_blocks
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,     // blk_id[14:0], zero pad
  input  logic [REQ_W-1:0]     s_tuser,     // req_type[1:0]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata      // status[0], is_free[1], allocated_block[16:2]
);

  localparam int WB_LOG    = $clog2(WORD_BITS);
  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W     = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;
  localparam int LIMIT_V   = (MAX_BLOCKS < OUT_LIMIT) ? MAX_BLOCKS : OUT_LIMIT;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DEC   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_RMW   = 3'd4;
  localparam logic [2:0] ST_SCAN  = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0]         state, state_next;
  logic [TOTAL_W-1:0] total_blocks;
  logic [REQ_W-1:0]   req, req_next;
  logic [BLK_W-1:0]   blk, blk_next;
  logic               res_status, res_status_next;
  logic               res_free, res_free_next;
  logic [BLK_W-1:0]   res_alloc, res_alloc_next;
  logic [ADDR_W-1:0]  clr_addr, clr_addr_next;
  logic [ADDR_W-1:0]  rd_addr, rd_addr_next;
  logic               pend, pend_next;
  logic [ADDR_W-1:0]  pend_addr, pend_addr_next;
  logic [ADDR_W-1:0]  last_word, last_word_next;

  logic [CMP_W-1:0]     total_ext;
  logic [CMP_W-1:0]     usable;
  logic [CMP_W-1:0]     blk_ext;
  logic [ADDR_W-1:0]    blk_word;
  logic [WB_LOG-1:0]    blk_bit;
  logic                 blk_in_map;
  logic [CMP_W-1:0]     pend_base;
  logic                 pend_last;
  logic                 scan_hit;
  logic [WB_LOG-1:0]    scan_idx;
  logic                 out_free;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  assign total_ext  = CMP_W'(total_blocks);
  assign usable     = (total_ext > CMP_W'(LIMIT_V)) ? CMP_W'(LIMIT_V) : total_ext;
  assign blk_ext    = CMP_W'(blk);
  assign blk_word   = ADDR_W'(blk_ext >> WB_LOG);
  assign blk_bit    = blk[WB_LOG-1:0];
  assign blk_in_map = blk_ext < CMP_W'(MAX_BLOCKS);
  assign pend_base  = CMP_W'(pend_addr) << WB_LOG;
  assign pend_last  = pend_addr == last_word;
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = state == ST_IDLE;

  fbba_ram #(
    .DATA_W (WORD_BITS),
    .DEPTH  (MAP_WORDS),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fbba_scan #(
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W),
    .WB_LOG    (WB_LOG)
  ) u_scan (
    .word  (ram_rdata),
    .base  (pend_base),
    .limit (usable),
    .hit   (scan_hit),
    .idx   (scan_idx)
  );

  always_comb begin
    state_next      = state;
    req_next        = req;
    blk_next        = blk;
    res_status_next = res_status;
    res_free_next   = res_free;
    res_alloc_next  = res_alloc;
    clr_addr_next   = clr_addr;
    rd_addr_next    = rd_addr;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    last_word_next  = last_word;
    ram_we          = 1'b0;
    ram_waddr       = blk_word;
    ram_wdata       = ram_rdata;
    ram_raddr       = blk_word;

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          req_next        = s_tuser;
          blk_next        = s_tdata[BLK_W-1:0];
          res_status_next = STATUS_OK;
          res_free_next   = 1'b0;
          res_alloc_next  = '0;
          state_next      = ST_DEC;
        end
      end
      ST_DEC: begin
        case (req)
          REQ_QUERY: begin
            state_next = ST_RD;
          end
          REQ_FREE: begin
            if (blk == '0) begin
              res_status_next = STATUS_FREE_ZERO;
              state_next      = ST_FIN;
            end else if (!blk_in_map) begin
              state_next = ST_FIN;
            end else begin
              state_next = ST_RD;
            end
          end
          REQ_ALLOC: begin
            if (usable <= CMP_W'(1)) begin
              state_next = ST_FIN;
            end else begin
              rd_addr_next   = '0;
              pend_next      = 1'b0;
              last_word_next = ADDR_W'((usable - CMP_W'(1)) >> WB_LOG);
              state_next     = ST_SCAN;
            end
          end
          default: begin
            state_next = ST_FIN;
          end
        endcase
      end
      ST_RD: begin
        state_next = ST_RMW;
      end
      ST_RMW: begin
        if (req == REQ_QUERY) begin
          res_free_next = (blk_ext < usable) && ram_rdata[blk_bit];
        end else begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (WORD_BITS'(1) << blk_bit);
        end
        state_next = ST_FIN;
      end
      ST_SCAN: begin
        ram_raddr      = rd_addr;
        rd_addr_next   = rd_addr + ADDR_W'(1);
        pend_next      = 1'b1;
        pend_addr_next = rd_addr;
        if (pend) begin
          if (scan_hit) begin
            ram_we         = 1'b1;
            ram_waddr      = pend_addr;
            ram_wdata      = ram_rdata & ~(WORD_BITS'(1) << scan_idx);
            res_alloc_next = BLK_W'(pend_base + CMP_W'(scan_idx));
            state_next     = ST_FIN;
          end else if (pend_last) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      pend         <= 1'b0;
      total_blocks <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pend     <= pend_next;
      if (cfg_we) begin
        total_blocks <= cfg_wdata;
      end
      if (state == ST_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    blk        <= blk_next;
    res_status <= res_status_next;
    res_free   <= res_free_next;
    res_alloc  <= res_alloc_next;
    rd_addr    <= rd_addr_next;
    pend_addr  <= pend_addr_next;
    last_word  <= last_word_next;
    if (state == ST_FIN && out_free) begin
      m_tdata <= {(M_TDATA_W - BLK_W - 2)'(0), res_alloc, res_free, res_status};
    end
  end

`ifndef ASSERT_OFF
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("bitmap written while idle");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:2] == '0 || CMP_W'(m_tdata[16:2]) < usable))
    else $error("allocated block outside usable range");

  a_status_alone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[16:1] == '0))
    else $error("free of block zero carries other fields");

  a_single_bit_update: assert property (@(posedge clk) disable iff (rst)
    (ram_we && (state == ST_RMW || state == ST_SCAN))
      |-> ($countones(ram_wdata ^ ram_rdata) <= 1))
    else $error("bitmap update changes more than one bit");

  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> (state == ST_CLEAR))
    else $error("clearing pass not started after reset");
`endif

endmodule
